// ----- hw/rtl/cgc_pkg.sv -----
`timescale 1ns / 1ps

package cgc_pkg;

    localparam int POS_W   = 32;
    localparam int GID_W   = 31;
    localparam int IDX_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CMD_W   = 2;
    localparam int STS_W   = 3;
    localparam int REG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

    // result status codes
    localparam logic [STS_W-1:0] ST_INSERTED    = 3'd0;
    localparam logic [STS_W-1:0] ST_PAIR        = 3'd1;
    localparam logic [STS_W-1:0] ST_NO_MORE     = 3'd2;
    localparam logic [STS_W-1:0] ST_OUT_OF_GRID = 3'd3;
    localparam logic [STS_W-1:0] ST_CELL_FULL   = 3'd4;
    localparam logic [STS_W-1:0] ST_CLEARED     = 3'd5;

    // configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_CELL_SIZE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN_X     = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Y     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_MIN_Z     = 2'd3;

    localparam logic [CFG_W-1:0] CELL_SIZE_RESET = 32'h0001_0000;

    localparam int NB_W     = 5;
    localparam logic [NB_W-1:0] NB_COUNT = 5'd27;
    localparam logic [NB_W-1:0] NB_SELF  = 5'd13;

    typedef struct packed {
        logic [CMD_W-1:0]        command;
        logic [GID_W-1:0]        particle_gid;
        logic                    local_flag;
        logic [IDX_W-1:0]        local_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } in_beat_t;

    typedef struct packed {
        logic [STS_W-1:0] status;
        logic [GID_W-1:0] gid_first;
        logic [GID_W-1:0] gid_second;
        logic             first_is_local;
        logic             second_is_local;
        logic [IDX_W-1:0] first_index;
        logic [IDX_W-1:0] second_index;
    } out_beat_t;

    typedef struct packed {
        logic [GID_W-1:0] gid;
        logic             local_flag;
        logic [IDX_W-1:0] index;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

    // controller to datapath
    typedef struct packed {
        logic             accept_clear;
        logic             accept_insert;
        logic             clr_step;
        logic             ins_read;
        logic             ins_commit;
        logic             cell_read;
        logic             fa_load;
        logic             next_cell;
        logic             next_nb;
        logic             nb_read;
        logic             fb_load;
        logic             self_skip;
        logic             next_first;
        logic             rd_a;
        logic             rd_b;
        logic             set_done;
        logic             out_load;
        logic [STS_W-1:0] out_status;
    } cgc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic out_of_grid;
        logic cell_full;
        logic scan_done;
        logic cell_end;
        logic cell_skip;
        logic nb_invalid;
        logic nb_skip;
        logic self_le;
        logic s_ge_fb;
        logic both_ghost;
        logic out_busy;
    } cgc_sts_t;

    // neighbour n -> {dx, dy, dz}, each 0..2 standing for -1..+1
    function automatic logic [5:0] nb_offset(input logic [NB_W-1:0] n);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < 27; i++) begin
            if (n == NB_W'(i)) begin
                r = {2'(i / 9), 2'((i / 3) % 3), 2'(i % 3)};
            end
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/cgc_ram.sv -----
`timescale 1ns / 1ps

module cgc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/cgc_div.sv -----
`timescale 1ns / 1ps

module cgc_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] div_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;
    logic [32:0] rem_sh;
    logic        ge;

    // one quotient bit per cycle, restoring
    assign rem_sh = {rem_reg[31:0], quo_reg[31]};
    assign ge     = rem_sh >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 6'd1);
            if (start)
            begin
                cnt_reg <= 6'd32;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/cgc_ctrl.sv -----
`timescale 1ns / 1ps

module cgc_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [cgc_pkg::CMD_W-1:0] in_command,
    output logic                    in_stall,
    input  cgc_pkg::cgc_sts_t       sts,
    output cgc_pkg::cgc_cmd_t       cmd
);

    import cgc_pkg::*;

    typedef enum logic [12:0] {
        S_CLR   = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_DIV   = 13'b0000000000100,
        S_IADR  = 13'b0000000001000,
        S_IFILL = 13'b0000000010000,
        S_CELL  = 13'b0000000100000,
        S_FA    = 13'b0000001000000,
        S_NB    = 13'b0000010000000,
        S_FB    = 13'b0000100000000,
        S_PAIR  = 13'b0001000000000,
        S_RDB   = 13'b0010000000000,
        S_CHK   = 13'b0100000000000,
        S_RESP  = 13'b1000000000000
    } state_t;

    state_t           state_reg, state_next;
    logic [STS_W-1:0] res_reg, res_next;
    logic             clr_resp_reg, clr_resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLR;
            res_reg      <= ST_CLEARED;
            clr_resp_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            res_reg      <= res_next;
            clr_resp_reg <= clr_resp_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        clr_resp_next  = clr_resp_reg;
        cmd            = '0;
        cmd.out_status = res_reg;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    res_next   = ST_CLEARED;
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_command)
                        CMD_CLEAR:
                        begin
                            cmd.accept_clear = 1'b1;
                            clr_resp_next    = 1'b1;
                            state_next       = S_CLR;
                        end
                        CMD_INSERT:
                        begin
                            cmd.accept_insert = 1'b1;
                            state_next        = S_DIV;
                        end
                        CMD_NEXT:
                        begin
                            if (sts.scan_done)
                            begin
                                res_next   = ST_NO_MORE;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                state_next = S_CELL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = S_IADR;
                end
            end
            S_IADR:
            begin
                if (sts.out_of_grid)
                begin
                    res_next   = ST_OUT_OF_GRID;
                    state_next = S_RESP;
                end
                else
                begin
                    cmd.ins_read = 1'b1;
                    state_next   = S_IFILL;
                end
            end
            S_IFILL:
            begin
                if (sts.cell_full)
                begin
                    res_next = ST_CELL_FULL;
                end
                else
                begin
                    cmd.ins_commit = 1'b1;
                    res_next       = ST_INSERTED;
                end
                state_next = S_RESP;
            end
            S_CELL:
            begin
                if (sts.cell_end)
                begin
                    cmd.set_done = 1'b1;
                    res_next     = ST_NO_MORE;
                    state_next   = S_RESP;
                end
                else
                begin
                    cmd.cell_read = 1'b1;
                    state_next    = S_FA;
                end
            end
            S_FA:
            begin
                cmd.fa_load = 1'b1;
                state_next  = S_NB;
            end
            S_NB:
            begin
                priority if (sts.cell_skip)
                begin
                    cmd.next_cell = 1'b1;
                    state_next    = S_CELL;
                end
                else if (sts.nb_invalid)
                begin
                    cmd.next_nb = 1'b1;
                end
                else
                begin
                    cmd.nb_read = 1'b1;
                    state_next  = S_FB;
                end
            end
            S_FB:
            begin
                cmd.fb_load = 1'b1;
                state_next  = S_PAIR;
            end
            S_PAIR:
            begin
                priority if (sts.nb_skip)
                begin
                    cmd.next_nb = 1'b1;
                    state_next  = S_NB;
                end
                else if (sts.self_le)
                begin
                    cmd.self_skip = 1'b1;
                end
                else if (sts.s_ge_fb)
                begin
                    cmd.next_first = 1'b1;
                end
                else
                begin
                    cmd.rd_a   = 1'b1;
                    state_next = S_RDB;
                end
            end
            S_RDB:
            begin
                cmd.rd_b   = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (sts.both_ghost)
                begin
                    state_next = S_PAIR;
                end
                else
                begin
                    res_next   = ST_PAIR;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/cgc_dp.sv -----
`timescale 1ns / 1ps

module cgc_dp #(
    parameter int GRID_DIM = 16,
    parameter int CELL_CAP = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cgc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [cgc_pkg::CFG_W-1:0]     cfg_data,
    input  cgc_pkg::in_beat_t             in_data,
    input  logic                          out_stall,
    output logic                          out_valid,
    output cgc_pkg::out_beat_t            out_data,
    input  cgc_pkg::cgc_cmd_t             cmd,
    output cgc_pkg::cgc_sts_t             sts
);

    import cgc_pkg::*;

    localparam int NUM_CELLS = GRID_DIM * GRID_DIM * GRID_DIM;
    localparam int NUM_SLOTS = NUM_CELLS * CELL_CAP;
    localparam int AW        = $clog2(NUM_CELLS);
    localparam int SAW       = $clog2(NUM_SLOTS);
    localparam int FW        = $clog2(CELL_CAP + 1);
    localparam int CW        = $clog2(GRID_DIM) + 1;
    localparam int NW        = CW + 1;

    // configuration
    logic [CFG_W-1:0] cell_size_reg, min_x_reg, min_y_reg, min_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg <= CELL_SIZE_RESET;
            min_x_reg     <= '0;
            min_y_reg     <= '0;
            min_z_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CELL_SIZE: cell_size_reg <= cfg_data;
                REG_MIN_X:     min_x_reg     <= cfg_data;
                REG_MIN_Y:     min_y_reg     <= cfg_data;
                REG_MIN_Z:     min_z_reg     <= cfg_data;
                default:       cell_size_reg <= cell_size_reg;
            endcase
        end
    end

    // insert: offsets and three dividers
    in_beat_t    in_reg;
    logic [32:0] off_x, off_y, off_z;
    logic [2:0]  neg_reg;
    logic [2:0]  div_done;
    logic [31:0] quo_x, quo_y, quo_z;

    assign off_x = {in_data.pos_x[31], in_data.pos_x} - {min_x_reg[31], min_x_reg};
    assign off_y = {in_data.pos_y[31], in_data.pos_y} - {min_y_reg[31], min_y_reg};
    assign off_z = {in_data.pos_z[31], in_data.pos_z} - {min_z_reg[31], min_z_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.accept_insert)
        begin
            in_reg  <= in_data;
            neg_reg <= {off_x[32], off_y[32], off_z[32]};
        end
    end

    cgc_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept_insert),
        .dividend (off_x[31:0]),
        .divisor  (cell_size_reg),
        .done     (div_done[0]),
        .quotient (quo_x)
    );

    cgc_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept_insert),
        .dividend (off_y[31:0]),
        .divisor  (cell_size_reg),
        .done     (div_done[1]),
        .quotient (quo_y)
    );

    cgc_div u_div_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.accept_insert),
        .dividend (off_z[31:0]),
        .divisor  (cell_size_reg),
        .done     (div_done[2]),
        .quotient (quo_z)
    );

    logic [AW-1:0] ins_lin;

    assign ins_lin = AW'((AW'(quo_x[CW-1:0]) * AW'(GRID_DIM) + AW'(quo_y[CW-1:0]))
                         * AW'(GRID_DIM) + AW'(quo_z[CW-1:0]));

    // scan position
    logic [CW-1:0]   x_reg, y_reg, z_reg;
    logic [NB_W-1:0] nb_reg;
    logic [FW-1:0]   first_reg, second_reg, b_reg;
    logic [FW-1:0]   fa_reg, fb_reg;
    logic            done_reg;
    logic [AW-1:0]   clr_reg;
    logic [AW-1:0]   cell_lin, nb_lin;
    logic [5:0]      off;
    logic [NW-1:0]   nx, ny, nz;
    logic            nb_ok;
    logic            rewind;

    assign rewind = cmd.accept_clear | cmd.ins_commit;

    assign cell_lin = AW'((AW'(x_reg) * AW'(GRID_DIM) + AW'(y_reg)) * AW'(GRID_DIM)
                          + AW'(z_reg));

    assign off = nb_offset(nb_reg);
    assign nx  = NW'(x_reg) + NW'(off[5:4]);
    assign ny  = NW'(y_reg) + NW'(off[3:2]);
    assign nz  = NW'(z_reg) + NW'(off[1:0]);
    assign nb_ok = (nx != '0) && (ny != '0) && (nz != '0) &&
                   (nx <= NW'(GRID_DIM)) && (ny <= NW'(GRID_DIM)) && (nz <= NW'(GRID_DIM));
    assign nb_lin = AW'((AW'(nx - NW'(1)) * AW'(GRID_DIM) + AW'(ny - NW'(1)))
                        * AW'(GRID_DIM) + AW'(nz - NW'(1)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            z_reg      <= '0;
            nb_reg     <= NB_SELF;
            first_reg  <= '0;
            second_reg <= '0;
            done_reg   <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            if (cmd.accept_clear)
            begin
                clr_reg <= '0;
            end
            else if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + AW'(1);
            end

            priority if (rewind)
            begin
                x_reg      <= '0;
                y_reg      <= '0;
                z_reg      <= '0;
                nb_reg     <= NB_SELF;
                first_reg  <= '0;
                second_reg <= '0;
                done_reg   <= 1'b0;
            end
            else if (cmd.set_done)
            begin
                x_reg    <= '0;
                done_reg <= 1'b1;
            end
            else if (cmd.next_cell)
            begin
                nb_reg     <= NB_SELF;
                first_reg  <= '0;
                second_reg <= '0;
                if (z_reg == CW'(GRID_DIM - 1))
                begin
                    z_reg <= '0;
                    if (y_reg == CW'(GRID_DIM - 1))
                    begin
                        y_reg <= '0;
                        x_reg <= x_reg + CW'(1);
                    end
                    else
                    begin
                        y_reg <= y_reg + CW'(1);
                    end
                end
                else
                begin
                    z_reg <= z_reg + CW'(1);
                end
            end
            else if (cmd.next_nb)
            begin
                nb_reg     <= nb_reg + NB_W'(1);
                first_reg  <= '0;
                second_reg <= '0;
            end
            else if (cmd.self_skip)
            begin
                second_reg <= first_reg + FW'(1);
            end
            else if (cmd.next_first)
            begin
                first_reg  <= first_reg + FW'(1);
                second_reg <= '0;
            end
            else if (cmd.rd_a)
            begin
                second_reg <= second_reg + FW'(1);
            end
        end
    end

    // cell fill memory
    logic          fill_we, fill_re;
    logic [AW-1:0] fill_waddr, fill_raddr;
    logic [FW-1:0] fill_wdata, fill_q;

    assign fill_we    = cmd.clr_step | cmd.ins_commit;
    assign fill_waddr = cmd.clr_step ? clr_reg : ins_lin;
    assign fill_wdata = cmd.clr_step ? '0 : fill_q + FW'(1);
    assign fill_re    = cmd.ins_read | cmd.cell_read | cmd.nb_read;

    always_comb
    begin
        priority if (cmd.ins_read)
        begin
            fill_raddr = ins_lin;
        end
        else if (cmd.cell_read)
        begin
            fill_raddr = cell_lin;
        end
        else
        begin
            fill_raddr = nb_lin;
        end
    end

    cgc_ram #(
        .WIDTH (FW),
        .DEPTH (NUM_CELLS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (fill_we),
        .waddr (fill_waddr),
        .wdata (fill_wdata),
        .re    (fill_re),
        .raddr (fill_raddr),
        .rdata (fill_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.fa_load)
        begin
            fa_reg <= fill_q;
        end
        if (cmd.fb_load)
        begin
            fb_reg <= fill_q;
        end
        if (cmd.rd_a)
        begin
            b_reg <= second_reg;
        end
    end

    // slot memory
    slot_t          slot_wdata, slot_q, a_reg;
    logic [SAW-1:0] slot_waddr, slot_raddr;

    assign slot_wdata = '{gid: in_reg.particle_gid, local_flag: in_reg.local_flag,
                          index: in_reg.local_index};
    assign slot_waddr = SAW'(SAW'(ins_lin) * SAW'(CELL_CAP) + SAW'(fill_q));
    assign slot_raddr = cmd.rd_a ? SAW'(SAW'(cell_lin) * SAW'(CELL_CAP) + SAW'(first_reg))
                                 : SAW'(SAW'(nb_lin) * SAW'(CELL_CAP) + SAW'(b_reg));

    cgc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (cmd.ins_commit),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (cmd.rd_a | cmd.rd_b),
        .raddr (slot_raddr),
        .rdata (slot_q)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.rd_b)
        begin
            a_reg <= slot_q;
        end
    end

    // result register
    logic      out_valid_reg;
    out_beat_t out_reg, out_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // particle fields stay zero unless a pair is reported
    always_comb
    begin
        out_next        = '0;
        out_next.status = cmd.out_status;
        if (cmd.out_status == ST_PAIR)
        begin
            out_next.gid_first       = a_reg.gid;
            out_next.gid_second      = slot_q.gid;
            out_next.first_is_local  = a_reg.local_flag;
            out_next.second_is_local = slot_q.local_flag;
            out_next.first_index     = a_reg.index;
            out_next.second_index    = slot_q.index;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // status back to the controller
    assign sts.clr_last    = (clr_reg == AW'(NUM_CELLS - 1));
    assign sts.div_done    = &div_done;
    assign sts.out_of_grid = (|neg_reg) || (quo_x >= 32'(GRID_DIM)) ||
                             (quo_y >= 32'(GRID_DIM)) || (quo_z >= 32'(GRID_DIM));
    assign sts.cell_full   = (fill_q >= FW'(CELL_CAP));
    assign sts.scan_done   = done_reg;
    assign sts.cell_end    = (x_reg == CW'(GRID_DIM));
    assign sts.cell_skip   = (fa_reg == '0) || (nb_reg >= NB_COUNT);
    assign sts.nb_invalid  = !nb_ok;
    assign sts.nb_skip     = (fb_reg == '0) || (first_reg >= fa_reg);
    assign sts.self_le     = (nb_reg == NB_SELF) && (second_reg <= first_reg);
    assign sts.s_ge_fb     = (second_reg >= fb_reg);
    assign sts.both_ghost  = !a_reg.local_flag && !slot_q.local_flag;
    assign sts.out_busy    = out_valid_reg && out_stall;

endmodule

// ----- hw/rtl/cell_grid_collision_pair_finder_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Beat
// config    in         cfg_we               cfg_index, cfg_data
// command   in         in_valid / in_stall  in_data (cgc_pkg::in_beat_t)
// result    out        out_valid / out_stall out_data (cgc_pkg::out_beat_t)
//
// Clear: one fill counter zeroed per cycle.
// Insert: three 32-step restoring dividers run side by side.
// Next pair: answers no-more when the scan has finished, otherwise visits
//   cells, neighbours inside the grid and slot pairs in turn, paced by the
//   single read port of each memory.
// After reset the fill memory is swept to zero with in_stall high;
//   configuration writes are taken meanwhile.
// A result waits in the output register under out_stall; the next command
//   is taken while it waits.

module cell_grid_collision_pair_finder_core #(
    parameter int GRID_DIM = 16,
    parameter int CELL_CAP = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [cgc_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [cgc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  cgc_pkg::in_beat_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output cgc_pkg::out_beat_t            out_data
);

    import cgc_pkg::*;

    cgc_cmd_t cmd;
    cgc_sts_t sts;

    // sequencing of clear, insert and the pair scan
    cgc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_stall   (in_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // dividers, scan counters, fill and slot memories, result register
    cgc_dp #(
        .GRID_DIM (GRID_DIM),
        .CELL_CAP (CELL_CAP)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- hw/rtl/cgc_chk.sv -----
`timescale 1ns / 1ps

module cgc_chk (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input cgc_pkg::in_beat_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input cgc_pkg::out_beat_t out_data
);

    import cgc_pkg::*;

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // one command at a time: a real command raises in_stall in the cycle after it is taken
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall &&
        (in_data.command == CMD_CLEAR || in_data.command == CMD_INSERT ||
         in_data.command == CMD_NEXT) |=> in_stall)
        else $error("command taken while previous one in flight");

    // only a pair carries particle fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_PAIR |->
        out_data.gid_first == '0 && out_data.gid_second == '0 &&
        out_data.first_index == '0 && out_data.second_index == '0 &&
        !out_data.first_is_local && !out_data.second_is_local)
        else $error("non-pair result carries particle fields");

    // a pair never joins two ghosts
    a_no_ghost_pair: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_PAIR |->
        out_data.first_is_local || out_data.second_is_local)
        else $error("ghost-ghost pair reported");

endmodule

bind cell_grid_collision_pair_finder_core cgc_chk u_cgc_chk (.*);
